[hdl/chta_pkg.sv]
// Shared types and constants for the clustered hash table with aging.
// Used by the top level; no dependencies of its own.
package chta_pkg;

  localparam int DEF_INDEX_BITS = 10;
  localparam int DEF_WAYS       = 3;

  localparam int KEY_W   = 64;
  localparam int SIG_LSB = 48;
  localparam int SIG_W   = 16;
  localparam int MOVE_W  = 16;
  localparam int SCORE_W = 16;
  localparam int DEPTH_W = 8;
  localparam int BOUND_W = 2;
  localparam int GEN_W   = 6;

  localparam int IN_DATA_W  = 128;
  localparam int IN_USED_W  = KEY_W + MOVE_W + 2 * SCORE_W + DEPTH_W + BOUND_W;
  localparam int OUT_DATA_W = 64;
  localparam int OUT_USED_W = MOVE_W + 2 * SCORE_W + DEPTH_W + BOUND_W;
  localparam int OUT_PAD_W  = OUT_DATA_W - OUT_USED_W;

  // 259 taken modulo 256, as the aged term only keeps the low byte.
  localparam logic [7:0] AGE_BIAS = 8'd3;
  localparam logic [8:0] DEPTH_MARGIN = 9'd3;

  typedef enum logic [1:0] {
    OP_PROBE      = 2'd0,
    OP_STORE      = 2'd1,
    OP_NEW_SEARCH = 2'd2,
    OP_CLEAR      = 2'd3
  } op_t;

  localparam logic [BOUND_W-1:0] BND_NONE  = 2'd0;
  localparam logic [BOUND_W-1:0] BND_LOWER = 2'd1;
  localparam logic [BOUND_W-1:0] BND_UPPER = 2'd2;
  localparam logic [BOUND_W-1:0] BND_EXACT = 2'd3;

  typedef struct packed {
    logic [SIG_W-1:0]   sig;
    logic [MOVE_W-1:0]  move;
    logic [SCORE_W-1:0] value;
    logic [SCORE_W-1:0] eval;
    logic [DEPTH_W-1:0] depth;
    logic [7:0]         age_bound;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

endpackage

[hdl/clustered_hash_table_with_aging_top.sv]
// Clustered hash table with aging: one RAM word per cluster, read-modify-write.
// Probe, store and age step: the cluster RAM is read as the beat is accepted
// and written back as the result is registered; no new beat is taken before that.
// Clear: one cluster zeroed per cycle over all clusters, then a result is given.
// Reset (rst_n low, synchronous) zeroes the age and starts a sweep over all
// 2^INDEX_BITS clusters of the RAM, during which in_tready stays low.
// Depends on chta_pkg and chta_ram.
module clustered_hash_table_with_aging_top #(
  parameter int INDEX_BITS = chta_pkg::DEF_INDEX_BITS,
  parameter int WAYS       = chta_pkg::DEF_WAYS
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // key[63:0], move[79:64], value[95:80], eval[111:96], depth[119:112],
  // bound[121:120], zero pad above
  input  logic [chta_pkg::IN_DATA_W-1:0]  in_tdata,
  // operation[1:0]
  input  logic [1:0]                      in_tuser,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // found_move[15:0], found_value[31:16], found_eval[47:32],
  // found_depth[55:48], found_bound[57:56], zero pad above
  output logic [chta_pkg::OUT_DATA_W-1:0] out_tdata,
  // hit[0]
  output logic [0:0]                      out_tuser
);

  localparam int CLUSTERS = 1 << INDEX_BITS;
  localparam int CL_W     = WAYS * chta_pkg::ENTRY_W;
  localparam int WAY_W    = (WAYS > 1) ? $clog2(WAYS) : 1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_CLEAR
  } state_t;

  state_t                           state_r;
  logic [INDEX_BITS-1:0]            cnt_r;
  logic                             clr_op_r;
  logic [chta_pkg::GEN_W-1:0]       gen_r;
  chta_pkg::op_t                    op_r;
  logic [INDEX_BITS-1:0]            idx_r;
  logic [chta_pkg::SIG_W-1:0]       sig_r;
  logic [chta_pkg::MOVE_W-1:0]      move_r;
  logic [chta_pkg::SCORE_W-1:0]     value_r;
  logic [chta_pkg::SCORE_W-1:0]     eval_r;
  logic [chta_pkg::DEPTH_W-1:0]     depth_r;
  logic [chta_pkg::BOUND_W-1:0]     bound_r;
  logic                             out_valid_r;
  logic [chta_pkg::OUT_DATA_W-1:0]  out_tdata_r;
  logic                             out_hit_r;

  logic                             in_acc;
  logic                             out_free;
  logic                             ram_we;
  logic [INDEX_BITS-1:0]            ram_waddr;
  logic [CL_W-1:0]                  ram_wdata;
  logic [CL_W-1:0]                  ram_rdata;

  chta_pkg::entry_t [WAYS-1:0]      rd_cl;
  chta_pkg::entry_t [WAYS-1:0]      wr_cl;
  logic signed [9:0]                score [WAYS];
  logic                             found;
  logic [WAY_W-1:0]                 pick;
  logic                             skip;
  logic                             do_write;
  logic                             hit_nxt;
  logic [chta_pkg::OUT_DATA_W-1:0]  out_tdata_nxt;

  assign in_tready  = (state_r == S_IDLE);
  assign in_acc     = in_tvalid && in_tready;
  assign out_free   = !out_valid_r || out_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_hit_r;

  assign rd_cl = ram_rdata;

  chta_ram #(
    .WIDTH (CL_W),
    .DEPTH (CLUSTERS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (in_acc),
    .raddr (in_tdata[INDEX_BITS-1:0]),
    .rdata (ram_rdata)
  );

  // Way selection and the read-modify-write of the cluster word.
  always_comb begin
    logic [7:0] aged_diff;
    logic [8:0] new_d;
    logic [8:0] old_d;
    found         = 1'b0;
    pick          = '0;
    skip          = 1'b0;
    do_write      = 1'b0;
    hit_nxt       = 1'b0;
    out_tdata_nxt = '0;
    wr_cl         = rd_cl;
    for (int w = 0; w < WAYS; w++) begin
      aged_diff = chta_pkg::AGE_BIAS + {gen_r, 2'b00} - rd_cl[w].age_bound;
      score[w]  = {{2{rd_cl[w].depth[7]}}, rd_cl[w].depth}
                  - {2'b00, aged_diff[7:2], 2'b00};
    end
    // First matching way wins; otherwise the lowest score, later way on a tie.
    for (int w = 0; w < WAYS; w++) begin
      if (!found) begin
        if (rd_cl[w].sig == sig_r) begin
          found = 1'b1;
          pick  = WAY_W'(w);
        end else if (score[pick] >= score[w]) begin
          pick = WAY_W'(w);
        end
      end
    end
    new_d = {depth_r[7], depth_r};
    old_d = {rd_cl[pick].depth[7], rd_cl[pick].depth} - chta_pkg::DEPTH_MARGIN;
    unique case (op_r)
      chta_pkg::OP_PROBE: begin
        if (found) begin
          wr_cl[pick].age_bound = {gen_r, rd_cl[pick].age_bound[1:0]};
          do_write      = 1'b1;
          hit_nxt       = 1'b1;
          out_tdata_nxt = {chta_pkg::OUT_PAD_W'(0), rd_cl[pick].age_bound[1:0],
                           rd_cl[pick].depth, rd_cl[pick].eval,
                           rd_cl[pick].value, rd_cl[pick].move};
        end
      end
      chta_pkg::OP_STORE: begin
        skip = (bound_r != chta_pkg::BND_EXACT) && found &&
               ($signed(new_d) < $signed(old_d));
        if (!skip) begin
          wr_cl[pick].sig       = sig_r;
          wr_cl[pick].move      = move_r;
          wr_cl[pick].value     = value_r;
          wr_cl[pick].eval      = eval_r;
          wr_cl[pick].depth     = depth_r;
          wr_cl[pick].age_bound = {gen_r, bound_r};
          do_write = 1'b1;
          hit_nxt  = 1'b1;
        end
      end
      chta_pkg::OP_NEW_SEARCH: begin
      end
      chta_pkg::OP_CLEAR: begin
      end
    endcase
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = idx_r;
    ram_wdata = wr_cl;
    if (state_r == S_CLEAR) begin
      ram_we    = 1'b1;
      ram_waddr = cnt_r;
      ram_wdata = '0;
    end else if (state_r == S_EXEC && out_free) begin
      ram_we = do_write;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      cnt_r       <= '0;
      clr_op_r    <= 1'b0;
      gen_r       <= '0;
      op_r        <= chta_pkg::OP_PROBE;
      out_valid_r <= 1'b0;
    end else begin
      if (state_r == S_EXEC && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            op_r    <= chta_pkg::op_t'(in_tuser);
            idx_r   <= in_tdata[INDEX_BITS-1:0];
            sig_r   <= in_tdata[chta_pkg::SIG_LSB +: chta_pkg::SIG_W];
            move_r  <= in_tdata[79:64];
            value_r <= in_tdata[95:80];
            eval_r  <= in_tdata[111:96];
            depth_r <= in_tdata[119:112];
            bound_r <= in_tdata[121:120];
            if (chta_pkg::op_t'(in_tuser) == chta_pkg::OP_CLEAR) begin
              state_r  <= S_CLEAR;
              cnt_r    <= '0;
              clr_op_r <= 1'b1;
            end else begin
              state_r <= S_EXEC;
            end
          end
        end
        S_EXEC: begin
          // The RAM holds its read data while the result slot is occupied.
          if (out_free) begin
            out_hit_r   <= hit_nxt;
            out_tdata_r <= out_tdata_nxt;
            if (op_r == chta_pkg::OP_NEW_SEARCH) begin
              gen_r <= gen_r + 1'b1;
            end
            state_r <= S_IDLE;
          end
        end
        S_CLEAR: begin
          cnt_r <= cnt_r + 1'b1;
          if (&cnt_r) begin
            clr_op_r <= 1'b0;
            state_r  <= clr_op_r ? S_EXEC : S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

endmodule

[hdl/chta_ram.sv]
// Generic simple dual-port RAM: one write port, one read port with a
// registered read. No dependencies.
module chta_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
